// ===== sv/wsdf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the WebSocket frame deframer.
// Depends on nothing; imported by websocket_frame_deframer.
package wsdf_pkg;

  // Header parsing phases.
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // Frame opcodes that the deframer recognises.
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Error codes reported in a result.
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_RSV         = 4'd1;
  localparam logic [3:0] ERR_CTRL_LONG   = 4'd2;
  localparam logic [3:0] ERR_CTRL_FRAG   = 4'd3;
  localparam logic [3:0] ERR_MSG_LONG    = 4'd4;
  localparam logic [3:0] ERR_ORPHAN      = 4'd5;
  localparam logic [3:0] ERR_EMPTY_FRAG  = 4'd6;
  localparam logic [3:0] ERR_BAD_OPCODE  = 4'd7;
  localparam logic [3:0] ERR_CLOSE       = 4'd8;
  localparam logic [3:0] ERR_UNKNOWN_CTL = 4'd9;

  // Configuration register indexes.
  localparam logic [0:0] REG_MAX_CONTROL = 1'b0;
  localparam logic [0:0] REG_MAX_MESSAGE = 1'b1;

  localparam logic [6:0]  MAX_CONTROL_RESET = 7'd125;
  localparam logic [15:0] MAX_MESSAGE_RESET = 16'd1024;

  // One result item.
  typedef struct packed {
    logic [3:0] error_code;
    logic       message_end;
    logic       frame_end;
    logic       kind;
    logic       has_byte;
    logic [7:0] out_byte;
  } result_t;

endpackage

// ===== sv/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// Server-side WebSocket deframer: header parser, checks, unmasking and output skid.
// Depends on wsdf_pkg for phases, opcodes, error codes and the result type.
//
// The block takes one received byte per transfer on the slave stream and
// accepts a new byte in every cycle: each byte is parsed and unmasked in the
// cycle it is accepted, and its result (if any) lands in an output register
// backed by a one-entry skid register, so a stalled master side only blocks
// the input once both are full. Header bytes give no result; the byte that
// completes the header of a zero-length data or ping frame gives a marker with
// has_byte low and tlast high; each data or ping payload byte gives one result.
// Pong payload is consumed silently. A failed header check gives one result
// that carries only the error code, after which every byte is accepted and
// dropped until reset. Configuration is written through the cfg channel
// (always ready) and must only be changed while the block is idle.
module websocket_frame_deframer #(
  parameter int MESSAGE_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Slave stream: tdata = in_byte[7:0].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // Master stream: tdata = out_byte[7:0], has_byte[8], message_end[9],
  // error_code[13:10], zero [15:14]; tuser = kind[0]; tlast = frame_end.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // Configuration write channel: index 0 max_control_len, 1 max_message_len.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import wsdf_pkg::*;

  localparam int MB = MESSAGE_COUNT_BITS;
  // Width of the message length comparison, one bit more than the wider operand.
  localparam int CW = ((MB > 16) ? MB : 16) + 1;
  localparam logic [MB-1:0] TOTAL_MAX = {MB{1'b1}};

  // Configuration registers.
  logic [6:0]  max_control_len;
  logic [15:0] max_message_len;

  // Parser state. frame_length keeps the low 16 bits of the length; len_big
  // records that a set bit was shifted beyond them, so the length is huge.
  phase_t          phase, phase_next;
  logic [2:0]      header_count, header_count_next;
  logic            fin_flag, fin_flag_next;
  logic [3:0]      frame_opcode, frame_opcode_next;
  logic [2:0]      rsv_bits, rsv_bits_next;
  logic            masked_flag, masked_flag_next;
  logic [15:0]     frame_length, frame_length_next;
  logic            len_big, len_big_next;
  logic [31:0]     mask_key, mask_key_next;
  logic [15:0]     payload_index, payload_index_next;
  logic [MB-1:0]   message_total, message_total_next;
  logic            error_latched, error_latched_next;

  // Output register and skid register.
  logic    out_valid, skid_valid;
  result_t out_res, skid_res;

  logic    s_accept, m_take;
  result_t res;
  logic    res_fire;

  // Scratch values of the parse step.
  logic [15:0]   len_lo_new;
  logic          len_big_new;
  logic          len_done, begin_pl;
  logic [3:0]    err_chk;
  logic          is_data;
  logic [7:0]    mask_byte;
  logic          last_byte;
  logic [CW-1:0] tot_cw, lim_cw, len_cw;

  assign s_axis_tready = !skid_valid;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_take        = out_valid && m_axis_tready;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_res.error_code, out_res.message_end,
                          out_res.has_byte, out_res.out_byte};
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tlast  = out_res.frame_end;

  assign is_data = !frame_opcode[3];
  assign tot_cw  = CW'(message_total);
  assign lim_cw  = CW'(max_message_len);

  // Header checks on the completed length, in the order the protocol demands.
  always_comb begin
    len_cw  = CW'(len_lo_new);
    err_chk = ERR_NONE;
    if (rsv_bits != 3'd0) begin
      err_chk = ERR_RSV;
    end else if (frame_opcode[3]) begin
      if (len_big_new || (len_lo_new > {9'd0, max_control_len})) begin
        err_chk = ERR_CTRL_LONG;
      end else if (!fin_flag) begin
        err_chk = ERR_CTRL_FRAG;
      end else if (frame_opcode == OP_CLOSE) begin
        err_chk = ERR_CLOSE;
      end else if (frame_opcode != OP_PING && frame_opcode != OP_PONG) begin
        err_chk = ERR_UNKNOWN_CTL;
      end
    end else if (frame_opcode == OP_BINARY || frame_opcode == OP_CONT) begin
      if (tot_cw > lim_cw) begin
        err_chk = ERR_MSG_LONG;
      end else if (len_big_new || (len_cw > (lim_cw - tot_cw))) begin
        err_chk = ERR_MSG_LONG;
      end else if (frame_opcode == OP_CONT && message_total == '0) begin
        err_chk = ERR_ORPHAN;
      end else if (len_lo_new == 16'd0 && !len_big_new && !fin_flag) begin
        err_chk = ERR_EMPTY_FRAG;
      end
    end else begin
      err_chk = ERR_BAD_OPCODE;
    end
  end

  // Mask byte for the current payload position, taken in received order.
  always_comb begin
    case (payload_index[1:0])
      2'd0:    mask_byte = mask_key[31:24];
      2'd1:    mask_byte = mask_key[23:16];
      2'd2:    mask_byte = mask_key[15:8];
      default: mask_byte = mask_key[7:0];
    endcase
  end

  assign last_byte = ({1'b0, payload_index} + 17'd1) >= {1'b0, frame_length};

  // Next state and result of one accepted byte.
  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    fin_flag_next      = fin_flag;
    frame_opcode_next  = frame_opcode;
    rsv_bits_next      = rsv_bits;
    masked_flag_next   = masked_flag;
    frame_length_next  = frame_length;
    len_big_next       = len_big;
    mask_key_next      = mask_key;
    payload_index_next = payload_index;
    message_total_next = message_total;
    error_latched_next = error_latched;
    len_lo_new         = frame_length;
    len_big_new        = len_big;
    len_done           = 1'b0;
    begin_pl           = 1'b0;
    res                = '0;
    res_fire           = 1'b0;

    if (s_accept && !error_latched) begin
      unique case (phase)
        PH_HDR0: begin
          fin_flag_next     = s_axis_tdata[7];
          rsv_bits_next     = s_axis_tdata[6:4];
          frame_opcode_next = s_axis_tdata[3:0];
          phase_next        = PH_HDR1;
        end
        PH_HDR1: begin
          masked_flag_next = s_axis_tdata[7];
          if (s_axis_tdata[6:0] == LEN_EXT16 || s_axis_tdata[6:0] == LEN_EXT64) begin
            frame_length_next = 16'd0;
            len_big_next      = 1'b0;
            header_count_next = (s_axis_tdata[6:0] == LEN_EXT16) ? 3'd1 : 3'd7;
            phase_next        = PH_EXT;
          end else begin
            len_lo_new  = {9'd0, s_axis_tdata[6:0]};
            len_big_new = 1'b0;
            len_done    = 1'b1;
          end
        end
        PH_EXT: begin
          len_big_new = len_big || (frame_length[15:8] != 8'd0);
          len_lo_new  = {frame_length[7:0], s_axis_tdata};
          if (header_count == 3'd0) begin
            len_done = 1'b1;
          end else begin
            frame_length_next = len_lo_new;
            len_big_next      = len_big_new;
            header_count_next = header_count - 3'd1;
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], s_axis_tdata};
          if (header_count == 3'd0) begin
            begin_pl = 1'b1;
          end else begin
            header_count_next = header_count - 3'd1;
          end
        end
        PH_PAYLOAD: begin
          payload_index_next = payload_index + 16'd1;
          if (is_data && message_total != TOTAL_MAX) begin
            message_total_next = message_total + MB'(1);
          end
          if (last_byte) begin
            if (is_data && fin_flag) begin
              message_total_next = '0;
            end
            phase_next        = PH_HDR0;
            header_count_next = 3'd0;
          end
          if (frame_opcode != OP_PONG) begin
            res_fire        = 1'b1;
            res.out_byte    = s_axis_tdata ^ mask_byte;
            res.has_byte    = 1'b1;
            res.kind        = !is_data;
            res.frame_end   = last_byte;
            res.message_end = last_byte && is_data && fin_flag;
          end
        end
        default: begin
          phase_next        = PH_HDR0;
          header_count_next = 3'd0;
        end
      endcase

      // Length complete: run the header checks.
      if (len_done) begin
        frame_length_next = len_lo_new;
        len_big_next      = len_big_new;
        mask_key_next     = 32'd0;
        if (err_chk != ERR_NONE) begin
          error_latched_next = 1'b1;
          res_fire           = 1'b1;
          res.error_code     = err_chk;
        end else if (masked_flag_next) begin
          phase_next        = PH_MASK;
          header_count_next = 3'd3;
        end else begin
          begin_pl = 1'b1;
        end
      end

      // Header complete: enter the payload, or close a zero-length frame.
      if (begin_pl) begin
        if (len_lo_new != 16'd0) begin
          phase_next         = PH_PAYLOAD;
          payload_index_next = 16'd0;
        end else begin
          if (is_data && fin_flag) begin
            message_total_next = '0;
          end
          phase_next        = PH_HDR0;
          header_count_next = 3'd0;
          if (frame_opcode != OP_PONG) begin
            res_fire        = 1'b1;
            res.kind        = !is_data;
            res.frame_end   = 1'b1;
            res.message_end = is_data && fin_flag;
          end
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR0;
      header_count    <= 3'd0;
      fin_flag        <= 1'b0;
      frame_opcode    <= 4'd0;
      rsv_bits        <= 3'd0;
      masked_flag     <= 1'b0;
      frame_length    <= 16'd0;
      len_big         <= 1'b0;
      mask_key        <= 32'd0;
      payload_index   <= 16'd0;
      message_total   <= '0;
      error_latched   <= 1'b0;
      max_control_len <= MAX_CONTROL_RESET;
      max_message_len <= MAX_MESSAGE_RESET;
      out_valid       <= 1'b0;
      skid_valid      <= 1'b0;
    end else begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      fin_flag      <= fin_flag_next;
      frame_opcode  <= frame_opcode_next;
      rsv_bits      <= rsv_bits_next;
      masked_flag   <= masked_flag_next;
      frame_length  <= frame_length_next;
      len_big       <= len_big_next;
      mask_key      <= mask_key_next;
      payload_index <= payload_index_next;
      message_total <= message_total_next;
      error_latched <= error_latched_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MAX_CONTROL: max_control_len <= cfg_data[6:0];
          REG_MAX_MESSAGE: max_message_len <= cfg_data;
          default:         max_message_len <= max_message_len;
        endcase
      end

      // The input is stalled while the skid register is full, so no new
      // result can arrive then.
      if (skid_valid) begin
        if (m_take) begin
          skid_valid <= 1'b0;
        end
      end else if (res_fire) begin
        if (out_valid && !m_take) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (m_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_take) begin
        out_res <= skid_res;
      end
    end else if (res_fire) begin
      if (out_valid && !m_take) begin
        skid_res <= res;
      end else begin
        out_res <= res;
      end
    end
  end

  // The skid register only fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // Once latched, the error stays until reset.
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_latched |=> error_latched)
    else $error("error latch cleared without reset");

  // An error result never carries a payload byte.
  a_error_no_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.error_code != ERR_NONE) |-> !out_res.has_byte)
    else $error("error result carries a payload byte");

  // A frame only enters its payload with a length that passed the checks.
  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (!len_big && frame_length != 16'd0))
    else $error("payload phase with an unchecked length");

  // After the error latches, accepted bytes add no further results.
  a_error_silent: assert property (@(posedge clk) disable iff (rst)
    (error_latched && !skid_valid && !out_valid) |=> !out_valid)
    else $error("result produced after the error latched");

endmodule
